FILE: design/fmmsc_pkg.sv
// shared types, constants and helper functions of the fuzzy min-max singleton controller
package fmmsc_pkg;

  localparam int NumInputs = 3;
  localparam int Sets      = 3;
  localparam int NumRules  = 3 ** NumInputs;
  localparam int RuleSlots = 27;
  localparam int MuW       = 7;
  localparam int RuleW     = 54;
  localparam int CfgIdxW   = 3;
  localparam int DivStages = 8;

  localparam logic [MuW-1:0] Full = MuW'(100);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BP0   = 3'd0,
    CFG_BP1   = 3'd1,
    CFG_BP2   = 3'd2,
    CFG_SING  = 3'd3,
    CFG_RULES = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MU_ZERO,
    MU_FULL,
    MU_DIV
  } mu_mode_t;

  typedef struct packed {
    mu_mode_t   mode;
    logic [7:0] num;
    logic [7:0] den;
  } mu_op_t;

  function automatic mu_op_t degree_op(logic signed [8:0] num, logic signed [8:0] den);
    mu_op_t op;
    op.num  = num[7:0];
    op.den  = den[7:0];
    if (num <= 9'sd0 || den <= 9'sd0) begin
      op.mode = MU_ZERO;
    end else if (num >= den) begin
      op.mode = MU_FULL;
    end else begin
      op.mode = MU_DIV;
    end
    return op;
  endfunction

  function automatic mu_op_t forced_op(mu_mode_t mode);
    mu_op_t op;
    op.mode = mode;
    op.num  = 8'd0;
    op.den  = 8'd1;
    return op;
  endfunction

  function automatic logic [MuW-1:0] max3(logic [MuW-1:0] a, logic [MuW-1:0] b,
                                          logic [MuW-1:0] c);
    logic [MuW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

FILE: design/fuzzy_min_max_singleton_controller_unit.sv
// top level of the fuzzy min-max controller with singleton defuzzification
//
// usage:
// - input channel: in_valid/in_stall carry crisp_a, crisp_b, crisp_c; a transaction
//   completes when in_valid is high and in_stall low
// - output channel: out_valid/out_stall carry crisp_result and no_rule_fired,
//   one result transaction per input transaction, in order
// - config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high; write only while the pipeline is empty
// - one item per cycle is sustained while out_stall does not hold a valid result
// - the depth is set by two 8-stage pipelined dividers (membership degrees and
//   the final weighted average) plus classify, scale, max-tree, product and sum stages
// - when out_stall holds a valid result, the whole pipeline freezes and in_stall
//   rises in the same cycle; nothing is lost or repeated
// - synchronous reset empties the pipeline and clears all config registers to zero
module fuzzy_min_max_singleton_controller_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [7:0]        crisp_a,
  input  logic signed [7:0]        crisp_b,
  input  logic signed [7:0]        crisp_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [7:0]        crisp_result,
  output logic                     no_rule_fired,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [fmmsc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fmmsc_pkg::RuleW-1:0]   cfg_data
);
  import fmmsc_pkg::*;

  localparam int Depth = 26;

  logic              en;
  logic [Depth-1:0]  v;

  logic [23:0]       bp [3];
  logic [23:0]       sing;
  logic [RuleW-1:0]  rules;

  logic signed [7:0] xin [3];

  mu_op_t            s1_op  [NumInputs][Sets];
  logic [15:0]       s2_num [NumInputs][Sets];
  logic [8:0]        s2_den [NumInputs][Sets];
  mu_mode_t          s2_mode [NumInputs][Sets];
  mu_mode_t          md [NumInputs][Sets][DivStages];
  logic [7:0]        q  [NumInputs][Sets];
  logic [MuW-1:0]    mu [NumInputs][Sets];
  logic [MuW-1:0]    rm [RuleSlots];
  logic [MuW-1:0]    g27 [Sets][RuleSlots];
  logic [MuW-1:0]    g9  [Sets][9];
  logic [MuW-1:0]    g3  [Sets][3];
  logic [MuW-1:0]    strength [Sets];
  logic signed [15:0] prod [Sets];
  logic [8:0]        den15;
  logic [15:0]       mag;
  logic [8:0]        den16;
  logic              neg16;
  logic              dz16;
  logic [DivStages-1:0] neg_d;
  logic [DivStages-1:0] dz_d;
  logic [7:0]        fq;

  assign en        = !(v[Depth-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v[Depth-1];
  assign cfg_ready = 1'b1;

  assign xin[0] = crisp_a;
  assign xin[1] = crisp_b;
  assign xin[2] = crisp_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      bp[0] <= '0;
      bp[1] <= '0;
      bp[2] <= '0;
      sing  <= '0;
      rules <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BP0:   bp[0] <= cfg_data[23:0];
        CFG_BP1:   bp[1] <= cfg_data[23:0];
        CFG_BP2:   bp[2] <= cfg_data[23:0];
        CFG_SING:  sing  <= cfg_data[23:0];
        CFG_RULES: rules <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Depth-2:0], in_valid};
    end
  end

  // fuzzification: classify, scale, divide, resolve
  for (genvar i = 0; i < NumInputs; i++) begin : g_in
    logic signed [8:0] x, p0, p1, p2;
    assign x  = 9'(xin[i]);
    assign p0 = 9'($signed(bp[i][7:0]));
    assign p1 = 9'($signed(bp[i][15:8]));
    assign p2 = 9'($signed(bp[i][23:16]));

    always_ff @(posedge clk) begin
      if (en) begin
        if (x <= p0)      s1_op[i][0] <= forced_op(MU_FULL);
        else if (x > p1)  s1_op[i][0] <= forced_op(MU_ZERO);
        else              s1_op[i][0] <= degree_op(p1 - x, p1 - p0);

        if (x <= p0 || x >= p2) s1_op[i][1] <= forced_op(MU_ZERO);
        else if (x >= p1)       s1_op[i][1] <= degree_op(p2 - x, p2 - p1);
        else                    s1_op[i][1] <= degree_op(x - p0, p1 - p0);

        if (x <= p1)       s1_op[i][2] <= forced_op(MU_ZERO);
        else if (x >= p2)  s1_op[i][2] <= forced_op(MU_FULL);
        else               s1_op[i][2] <= degree_op(x - p1, p2 - p1);
      end
    end

    for (genvar j = 0; j < Sets; j++) begin : g_set
      always_ff @(posedge clk) begin
        if (en) begin
          s2_num[i][j]  <= 16'(s1_op[i][j].num) * 16'd100;
          s2_den[i][j]  <= {1'b0, s1_op[i][j].den};
          s2_mode[i][j] <= s1_op[i][j].mode;
          md[i][j][0]   <= s2_mode[i][j];
          for (int k = 1; k < DivStages; k++) begin
            md[i][j][k] <= md[i][j][k-1];
          end
          case (md[i][j][DivStages-1])
            MU_FULL: mu[i][j] <= Full;
            MU_DIV:  mu[i][j] <= q[i][j][MuW-1:0];
            default: mu[i][j] <= '0;
          endcase
        end
      end

      fmmsc_div u_div (
        .clk (clk),
        .en  (en),
        .num (s2_num[i][j]),
        .den (s2_den[i][j]),
        .quo (q[i][j])
      );
    end
  end

  // rule strengths as minimum over memberships
  for (genvar r = 0; r < RuleSlots; r++) begin : g_rule
    localparam int D0 = r % 3;
    localparam int D1 = (r / 3) % 3;
    localparam int D2 = (r / 9) % 3;
    if (r >= NumRules) begin : g_unused
      assign rm[r] = '0;
    end else if (NumInputs == 1) begin : g_one
      assign rm[r] = mu[0][D0];
    end else if (NumInputs == 2) begin : g_two
      assign rm[r] = (mu[0][D0] < mu[1][D1]) ? mu[0][D0] : mu[1][D1];
    end else begin : g_three
      logic [MuW-1:0] m01;
      assign m01   = (mu[0][D0] < mu[1][D1]) ? mu[0][D0] : mu[1][D1];
      assign rm[r] = (m01 < mu[2][D2]) ? m01 : mu[2][D2];
    end
  end

  // per output set maximum through a three-level registered tree
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < Sets; s++) begin
        for (int r = 0; r < RuleSlots; r++) begin
          g27[s][r] <= (rules[2*r +: 2] == 2'(s)) ? rm[r] : '0;
        end
        for (int k = 0; k < 9; k++) begin
          g9[s][k] <= max3(g27[s][3*k], g27[s][3*k+1], g27[s][3*k+2]);
        end
        for (int k = 0; k < 3; k++) begin
          g3[s][k] <= max3(g9[s][3*k], g9[s][3*k+1], g9[s][3*k+2]);
        end
        strength[s] <= max3(g3[s][0], g3[s][1], g3[s][2]);
        prod[s] <= $signed(sing[8*s +: 8]) * $signed({1'b0, strength[s]});
      end
      den15 <= 9'(strength[0]) + 9'(strength[1]) + 9'(strength[2]);
    end
  end

  // weighted sum, magnitude and sign for the final division, and the signed result
  always_ff @(posedge clk) begin
    logic signed [17:0] sum;
    if (en) begin
      sum   = 18'(prod[0]) + 18'(prod[1]) + 18'(prod[2]);
      neg16 <= sum < 18'sd0;
      mag   <= (sum < 18'sd0) ? 16'(-sum) : 16'(sum);
      den16 <= den15;
      dz16  <= den15 == 9'd0;
      neg_d <= {neg_d[DivStages-2:0], neg16};
      dz_d  <= {dz_d[DivStages-2:0], dz16};
      if (dz_d[DivStages-1]) begin
        crisp_result <= '0;
      end else if (neg_d[DivStages-1]) begin
        crisp_result <= -$signed(fq);
      end else begin
        crisp_result <= $signed(fq);
      end
      no_rule_fired <= dz_d[DivStages-1];
    end
  end

  fmmsc_div u_avg_div (
    .clk (clk),
    .en  (en),
    .num (mag),
    .den ((den16 == 9'd0) ? 9'd1 : den16),
    .quo (fq)
  );

  a_stall_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output hold");

  a_no_rule_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_rule_fired) |-> (crisp_result == 8'sd0))
    else $error("no rule fired but result is not zero");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(v)))
    else $error("pipeline moved while the output was held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

FILE: design/fmmsc_div.sv
// pipelined restoring divider, one quotient bit per stage, quotient below 256
module fmmsc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] num,
  input  logic [8:0]  den,
  output logic [7:0]  quo
);
  import fmmsc_pkg::*;

  logic [15:0] rem [DivStages];
  logic [8:0]  dd  [DivStages];
  logic [7:0]  qq  [DivStages];

  always_ff @(posedge clk) begin
    logic [16:0] sh;
    logic [16:0] r;
    if (en) begin
      r  = {1'b0, num};
      sh = 17'(den) << (DivStages - 1);
      dd[0] <= den;
      if (r >= sh) begin
        rem[0] <= 16'(r - sh);
        qq[0]  <= 8'd1 << (DivStages - 1);
      end else begin
        rem[0] <= num;
        qq[0]  <= 8'd0;
      end
      for (int k = 1; k < DivStages; k++) begin
        r  = {1'b0, rem[k-1]};
        sh = 17'(dd[k-1]) << (DivStages - 1 - k);
        dd[k] <= dd[k-1];
        if (r >= sh) begin
          rem[k] <= 16'(r - sh);
          qq[k]  <= qq[k-1] | (8'd1 << (DivStages - 1 - k));
        end else begin
          rem[k] <= r[15:0];
          qq[k]  <= qq[k-1];
        end
      end
    end
  end

  assign quo = qq[DivStages-1];

endmodule
